// ===== design/hrc_pkg.sv =====
package hrc_pkg;

	// Packed stream word width: six fields, 47 bits, padded to whole bytes.
	localparam int DataW = 48;

	localparam int RedLo   = 0;
	localparam int GreenLo = 8;
	localparam int BlueLo  = 16;
	localparam int HueLo   = 24;
	localparam int SatLo   = 33;
	localparam int BriLo   = 40;

	// Quotient bits of the shared restoring divider (hue needs up to 300).
	localparam int QBits = 9;

	// Reciprocal constants for division by fixed denominators.
	localparam int KV = 15;
	localparam int DV = 100;
	localparam int RV = (1 << KV) / DV;
	localparam int KP = 22;
	localparam int DP = 10000;
	localparam int RP = (1 << KP) / DP;
	localparam int KQ = 28;
	localparam int DQ = 600000;
	localparam int RQ = (1 << KQ) / DQ;
	localparam int KB = 15;
	localparam int DB = 255;
	localparam int RB = (1 << KB) / DB;

	localparam logic [2:0] SecRed    = 3'd0;
	localparam logic [2:0] SecYellow = 3'd1;
	localparam logic [2:0] SecGreen  = 3'd2;
	localparam logic [2:0] SecCyan   = 3'd3;
	localparam logic [2:0] SecBlue   = 3'd4;

	typedef struct packed {
		logic [16:0] hn;
		logic [7:0]  c;
		logic        neg;
		logic        gray;
		logic [14:0] sn;
		logic [7:0]  m;
	} rgb_t;

	typedef struct packed {
		logic        kind;
		logic [16:0] hrem;
		logic [8:0]  hq;
		logic [7:0]  c;
		logic        neg;
		logic        gray;
		logic [16:0] srem;
		logic [8:0]  sq;
		logic [7:0]  m;
		logic [6:0]  bri;
		logic [7:0]  ro;
		logic [7:0]  go;
		logic [7:0]  bo;
	} dstage_t;

	// The reciprocal estimate is at most one below the true quotient.
	function automatic logic [7:0] fix_quot(input logic [27:0] num, input logic [7:0] q0,
			input logic [19:0] den);
		logic [27:0] rem;
		rem = num - 28'(28'(q0) * 28'(den));
		return q0 + 8'(rem >= 28'(den));
	endfunction

endpackage

// ===== design/hsv_rgb_converter.sv =====
// Channel | Dir | Transfer when                    | Payload
// s_axis  | in  | s_axis_tvalid && s_axis_tready   | tuser: kind, tdata: pixel fields
// m_axis  | out | m_axis_tvalid && m_axis_tready   | tdata: result fields
// One pixel per cycle is accepted while the output is not stalled.
// The depth is set by four arithmetic stages, a nine-stage restoring divider shared by
// hue and saturation, and the output register, 14 register stages in all.
// Reset clears only the valid bits of every stage.
// A stall at the output holds the whole pipeline in place; nothing is lost or repeated.
module hsv_rgb_converter import hrc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [DataW-1:0] s_axis_tdata,  // red, green, blue, hue, saturation, brightness
	input  logic             s_axis_tuser,  // kind
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [DataW-1:0] m_axis_tdata   // out_red, out_green, out_blue, out_hue,
	                                        // out_saturation, out_brightness
);

	logic en;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// Stage 1: channel extremes, hue sector numerators, clamping.
	logic        vld_s1, kind_s1, s0_s1;
	rgb_t        rgb_s1, rgb_n1;
	logic [14:0] bn_s1, bn_n1;
	logic [2:0]  sec_s1, sec_n1;
	logic [6:0]  vc_s1, vc_n1;
	logic [13:0] vs_s1, vs_n1;
	logic [12:0] sfr_s1, sfr_n1, sfr2_s1, sfr2_n1;
	logic        s0_n1;

	always_comb begin
		int r, g, b, mx, mn, cc, num, an, hh, ss, vv, sec, fr;
		r = int'(s_axis_tdata[RedLo +: 8]);
		g = int'(s_axis_tdata[GreenLo +: 8]);
		b = int'(s_axis_tdata[BlueLo +: 8]);
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		cc = mx - mn;
		if (mx == b) begin
			num = 60 * (r - g) + 240 * cc;
		end else if (mx == g) begin
			num = 60 * (b - r) + 120 * cc;
		end else begin
			num = 60 * (g - b);
		end
		an = (num < 0) ? -num : num;
		// Rounding half away from zero: floor((|num| + c/2) / c).
		rgb_n1.hn   = 17'(an + cc / 2);
		rgb_n1.c    = 8'(cc);
		rgb_n1.neg  = num < 0;
		rgb_n1.gray = cc == 0;
		rgb_n1.sn   = 15'(100 * cc + mx / 2);
		rgb_n1.m    = 8'(mx);
		bn_n1       = 15'(100 * mx + 127);

		hh = int'(s_axis_tdata[HueLo +: 9]);
		ss = int'(s_axis_tdata[SatLo +: 7]);
		vv = int'(s_axis_tdata[BriLo +: 7]);
		if (hh > 360) hh = 360;
		if (hh == 360) hh = 0;
		if (ss > 100) ss = 100;
		if (vv > 100) vv = 100;
		if (hh >= 300) sec = 5;
		else if (hh >= 240) sec = 4;
		else if (hh >= 180) sec = 3;
		else if (hh >= 120) sec = 2;
		else if (hh >= 60) sec = 1;
		else sec = 0;
		fr = hh - 60 * sec;
		sec_n1  = 3'(sec);
		vc_n1   = 7'(vv);
		vs_n1   = 14'(vv * (100 - ss));
		sfr_n1  = 13'(ss * fr);
		sfr2_n1 = 13'(ss * (60 - fr));
		s0_n1   = ss == 0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= s_axis_tuser;
			rgb_s1  <= rgb_n1;
			bn_s1   <= bn_n1;
			sec_s1  <= sec_n1;
			vc_s1   <= vc_n1;
			vs_s1   <= vs_n1;
			sfr_s1  <= sfr_n1;
			sfr2_s1 <= sfr2_n1;
			s0_s1   <= s0_n1;
		end
	end

	// Stage 2: numerators of v, p, q and t.
	logic        vld_s2, kind_s2, s0_s2;
	rgb_t        rgb_s2;
	logic [14:0] bn_s2, nvv_s2;
	logic [2:0]  sec_s2;
	logic [21:0] np_s2;
	logic [27:0] nq_s2, nt_s2;
	logic [27:0] nq_n2, nt_n2;

	always_comb begin
		int xq, xt;
		xq = int'(vc_s1) * (6000 - int'(sfr_s1));
		xt = int'(vc_s1) * (6000 - int'(sfr2_s1));
		nq_n2 = 28'(xq * 256 - xq);
		nt_n2 = 28'(xt * 256 - xt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s2 <= kind_s1;
			rgb_s2  <= rgb_s1;
			bn_s2   <= bn_s1;
			sec_s2  <= sec_s1;
			s0_s2   <= s0_s1;
			nvv_s2  <= 15'(int'(vc_s1) * 255);
			np_s2   <= 22'(int'(vs_s1) * 255);
			nq_s2   <= nq_n2;
			nt_s2   <= nt_n2;
		end
	end

	// Stage 3: reciprocal estimates of the constant divisions.
	logic        vld_s3, kind_s3, s0_s3;
	rgb_t        rgb_s3;
	logic [14:0] bn_s3, nvv_s3;
	logic [2:0]  sec_s3;
	logic [21:0] np_s3;
	logic [27:0] nq_s3, nt_s3;
	logic [7:0]  qv_s3, qp_s3, qq_s3, qt_s3, qb_s3;
	logic [47:0] pv, pp, pq, pt, pb;

	always_comb begin
		pv = 48'(nvv_s2) * 48'(RV);
		pp = 48'(np_s2) * 48'(RP);
		pq = 48'(nq_s2) * 48'(RQ);
		pt = 48'(nt_s2) * 48'(RQ);
		pb = 48'(bn_s2) * 48'(RB);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s3 <= kind_s2;
			rgb_s3  <= rgb_s2;
			bn_s3   <= bn_s2;
			sec_s3  <= sec_s2;
			s0_s3   <= s0_s2;
			nvv_s3  <= nvv_s2;
			np_s3   <= np_s2;
			nq_s3   <= nq_s2;
			nt_s3   <= nt_s2;
			qv_s3   <= pv[KV +: 8];
			qp_s3   <= pp[KP +: 8];
			qq_s3   <= pq[KQ +: 8];
			qt_s3   <= pt[KQ +: 8];
			qb_s3   <= pb[KB +: 8];
		end
	end

	// Stage 4: quotient correction, channel selection, divider setup.
	logic    vld_s4;
	dstage_t st_s4, st_n4;

	always_comb begin
		logic [7:0] vv, p, q, t, bq;
		vv = fix_quot(28'(nvv_s3), qv_s3, 20'(DV));
		p  = fix_quot(28'(np_s3), qp_s3, 20'(DP));
		q  = fix_quot(nq_s3, qq_s3, 20'(DQ));
		t  = fix_quot(nt_s3, qt_s3, 20'(DQ));
		bq = fix_quot(28'(bn_s3), qb_s3, 20'(DB));
		st_n4.kind = kind_s3;
		st_n4.hrem = rgb_s3.hn;
		st_n4.hq   = '0;
		st_n4.c    = rgb_s3.c;
		st_n4.neg  = rgb_s3.neg;
		st_n4.gray = rgb_s3.gray;
		st_n4.srem = 17'(rgb_s3.sn);
		st_n4.sq   = '0;
		st_n4.m    = rgb_s3.m;
		st_n4.bri  = bq[6:0];
		if (s0_s3) begin
			st_n4.ro = vv;
			st_n4.go = vv;
			st_n4.bo = vv;
		end else begin
			case (sec_s3)
				SecRed: begin
					st_n4.ro = vv; st_n4.go = t; st_n4.bo = p;
				end
				SecYellow: begin
					st_n4.ro = q; st_n4.go = vv; st_n4.bo = p;
				end
				SecGreen: begin
					st_n4.ro = p; st_n4.go = vv; st_n4.bo = t;
				end
				SecCyan: begin
					st_n4.ro = p; st_n4.go = q; st_n4.bo = vv;
				end
				SecBlue: begin
					st_n4.ro = t; st_n4.go = p; st_n4.bo = vv;
				end
				default: begin
					st_n4.ro = vv; st_n4.go = p; st_n4.bo = q;
				end
			endcase
		end
		if (!kind_s3) begin
			st_n4.ro = '0;
			st_n4.go = '0;
			st_n4.bo = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s4 <= st_n4;
		end
	end

	// Restoring divider: one quotient bit of hue and saturation per stage.
	dstage_t            div_s [QBits];
	logic [QBits-1:0]   dvld_s;

	for (genvar k = 0; k < QBits; k++) begin : g_div
		dstage_t din, dnext;
		logic    vin;
		logic [16:0] hsh, ssh;

		if (k == 0) begin : g_first
			assign din = st_s4;
			assign vin = vld_s4;
		end else begin : g_next
			assign din = div_s[k-1];
			assign vin = dvld_s[k-1];
		end

		always_comb begin
			dnext = din;
			hsh = 17'(din.c) << (QBits - 1 - k);
			ssh = 17'(din.m) << (QBits - 1 - k);
			if (din.hrem >= hsh) begin
				dnext.hrem = din.hrem - hsh;
				dnext.hq[QBits-1-k] = 1'b1;
			end
			if (din.srem >= ssh) begin
				dnext.srem = din.srem - ssh;
				dnext.sq[QBits-1-k] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvld_s[k] <= 1'b0;
			end else if (en) begin
				dvld_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k] <= dnext;
			end
		end
	end

	// Output stage: hue sign and wrap, field packing.
	logic [DataW-1:0] res_n;

	always_comb begin
		dstage_t    d;
		logic [8:0] h;
		logic [6:0] s;
		d = div_s[QBits-1];
		if (d.gray) begin
			h = '0;
		end else if (d.neg) begin
			h = (d.hq == '0) ? 9'd0 : 9'(9'd360 - d.hq);
		end else if (d.hq >= 9'd360) begin
			h = 9'(d.hq - 9'd360);
		end else begin
			h = d.hq;
		end
		s = (d.m == '0) ? 7'd0 : d.sq[6:0];
		res_n = '0;
		res_n[RedLo +: 8]   = d.ro;
		res_n[GreenLo +: 8] = d.go;
		res_n[BlueLo +: 8]  = d.bo;
		if (!d.kind) begin
			res_n[HueLo +: 9] = h;
			res_n[SatLo +: 7] = s;
			res_n[BriLo +: 7] = d.bri;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= dvld_s[QBits-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= res_n;
		end
	end

endmodule

// ===== design/hrc_checker.sv =====
module hrc_checker import hrc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic [DataW-1:0] s_axis_tdata,
	input logic             s_axis_tuser,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [DataW-1:0] m_axis_tdata
);

	// A result that is not taken stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output transfer dropped or changed while stalled");

	// The input side may only stall while a result waits.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with an empty output register");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[HueLo +: 9] < 9'd360
			&& m_axis_tdata[SatLo +: 7] <= 7'd100
			&& m_axis_tdata[BriLo +: 7] <= 7'd100
			&& m_axis_tdata[DataW-1] == 1'b0)
		else $error("result field out of range");

	// Only one direction of conversion fills a result.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[BriLo +: 7] != 7'd0
			|| m_axis_tdata[SatLo +: 7] != 7'd0 || m_axis_tdata[HueLo +: 9] != 9'd0)
		|-> m_axis_tdata[BlueLo +: 8] == 8'd0 && m_axis_tdata[GreenLo +: 8] == 8'd0
			&& m_axis_tdata[RedLo +: 8] == 8'd0)
		else $error("both color spaces present in one result");

endmodule

bind hsv_rgb_converter hrc_checker u_hrc_checker (.*);
